@@ rtl/bounded_deque_engine_unit_assert.svh @@
// assertion macros for the deque engine, clocked on i_clk, quiet during reset
`ifndef BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define BDE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque engine check failed");

// next-cycle implication
`define BDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque engine check failed");

`endif

@@ rtl/bde_pkg.sv @@
package bde_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CAP_W   = 5;
    localparam int EW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W   = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request queue between front and back
    localparam int QD      = 2;
    localparam int QA_W    = $clog2(QD);
    localparam int QC_W    = $clog2(QD + 1);

    // result queue at the output
    localparam int OUTD    = 4;
    localparam int OA_W    = $clog2(OUTD);
    localparam int OC_W    = $clog2(OUTD + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_L = 3'd0,
        CMD_PUSH_R = 3'd1,
        CMD_POP_L  = 3'd2,
        CMD_POP_R  = 3'd3,
        CMD_ASK_F  = 3'd4,
        CMD_ASK_E  = 3'd5,
        CMD_PEEK_L = 3'd6,
        CMD_PEEK_R = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ELEM   = 2'd1,
        KIND_ANSWER = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // classified request; for asks, left selects the full question
    typedef struct packed {
        logic             is_push;
        logic             is_pop;
        logic             is_ask;
        logic             is_peek;
        logic             left;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_kind            kind;
        t_status          status;
        logic             answer;
        logic [VAL_W-1:0] element;
        logic             last;
    } t_result;

    // (a + b) mod DEPTH, valid for a < DEPTH and b <= DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/bounded_deque_engine_unit.sv @@
// path from acceptance to the result ports: request queue, back end, result queue, plus the
//   registered storage read for peeks and listed elements; a listing request holds the back end
//   until its last element is read, one element per cycle while the result queue has room
// reset: synchronous active low, empties the deque, sets capacity to 16, flushes both
//   queues; element storage is not cleared and needs no clearing pass
`include "bounded_deque_engine_unit_assert.svh"

module bounded_deque_engine_unit import bde_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [2:0]              i_command,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_kind,
    output logic [1:0]              o_status,
    output logic                    o_answer,
    output logic signed [VAL_W-1:0] o_element,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_capacity
);

    logic    q_full, q_empty, q_we, q_take;
    t_req    f_req, q_req;
    t_result res;

    assign o_cfg_ready = 1'b1;

    bde_front u_front (
        .i_push    (push),
        .i_command (i_command),
        .i_value   (i_value),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_we    (q_we),
        .o_req     (f_req)
    );

    bde_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (q_we),
        .i_data  (f_req),
        .i_re    (q_take),
        .o_data  (q_req),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (~q_empty),
        .i_req       (q_req),
        .o_req_take  (q_take),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_capacity),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_kind    = res.kind;
    assign o_status  = res.status;
    assign o_answer  = res.answer;
    assign o_element = res.element;
    assign o_last    = res.last;

    `BDE_ASSERT_NOW(a_single_ends, !empty && o_kind != KIND_ELEM, o_last)
    `BDE_ASSERT_NOW(a_error_status, !empty && o_kind == KIND_STATUS, o_status != ST_OK)
    `BDE_ASSERT_NOW(a_answer_only, !empty && o_kind != KIND_ANSWER, !o_answer)
    `BDE_ASSERT_NEXT(a_take_pops_queue, q_take && !q_we && !q_full, !q_full)

endmodule

@@ rtl/bde_front.sv @@
module bde_front import bde_pkg::*; (
    input  logic             i_push,
    input  logic [2:0]       i_command,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_q_full,
    output logic             o_full,
    output logic             o_q_we,
    output t_req             o_req
);

    t_cmd cmd;

    assign cmd    = t_cmd'(i_command);
    assign o_full = i_q_full;
    assign o_q_we = i_push & ~i_q_full;

    always_comb begin
        o_req         = '0;
        o_req.value   = i_value;
        o_req.is_push = cmd inside {CMD_PUSH_L, CMD_PUSH_R};
        o_req.is_pop  = cmd inside {CMD_POP_L, CMD_POP_R};
        o_req.is_ask  = cmd inside {CMD_ASK_F, CMD_ASK_E};
        o_req.is_peek = cmd inside {CMD_PEEK_L, CMD_PEEK_R};
        case (cmd)
            CMD_PUSH_L, CMD_POP_L, CMD_ASK_F, CMD_PEEK_L: begin
                o_req.left = 1'b1;
            end
            default: begin
                o_req.left = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/bde_cmdq.sv @@
module bde_cmdq import bde_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_we,
    input  t_req i_data,
    input  logic i_re,
    output t_req o_data,
    output logic o_full,
    output logic o_empty
);

    t_req             r_ent [QD];
    logic [QA_W-1:0]  r_wptr, n_wptr;
    logic [QA_W-1:0]  r_rptr, n_rptr;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == QC_W'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_ent[r_rptr];
    assign do_wr   = i_we & ~o_full;
    assign do_rd   = i_re & ~o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (do_wr) begin
            n_wptr = (r_wptr == QA_W'(QD - 1)) ? '0 : r_wptr + QA_W'(1);
        end
        if (do_rd) begin
            n_rptr = (r_rptr == QA_W'(QD - 1)) ? '0 : r_rptr + QA_W'(1);
        end
        n_cnt = r_cnt + QC_W'(do_wr) - QC_W'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_ent[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ rtl/bde_back.sv @@
module bde_back import bde_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  t_req             i_req,
    output logic             o_req_take,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    output t_result          o_res,
    output logic             o_empty,
    input  logic             i_pop
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } t_state;

    logic [VAL_W-1:0] slots [DEPTH];

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CAP_W-1:0] r_cap;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic [VAL_W-1:0] r_rd_data;

    t_result          r_oq [OUTD];
    logic [OA_W-1:0]  r_owp, n_owp;
    logic [OA_W-1:0]  r_orp, n_orp;
    logic [OC_W-1:0]  r_occ, n_occ;

    logic [EW-1:0]    eff_cap;
    logic             is_full, is_empty, out_room, take;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic             direct_vld, oq_we, oq_re;
    t_result          direct_res, oq_wdata;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = EW'(1);
        end else if (EW'(r_cap) > EW'(DEPTH)) begin
            eff_cap = EW'(DEPTH);
        end else begin
            eff_cap = EW'(r_cap);
        end
    end

    assign is_full  = (EW'(r_count) >= eff_cap);
    assign is_empty = (r_count == '0);
    // room for one more entry counting the read still in flight
    assign out_room = ((r_occ + OC_W'(r_rd_vld)) < OC_W'(OUTD));
    assign take     = (r_state == S_IDLE) && i_req_valid && !r_rd_vld && out_room;
    assign o_req_take = take;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_pos      = r_pos;
        n_rd_vld   = 1'b0;
        n_rd_last  = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = r_head;
        rd_addr    = r_head;
        direct_vld = 1'b0;
        direct_res = '0;
        direct_res.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_req.is_push) begin
                        if (is_full) begin
                            direct_vld        = 1'b1;
                            direct_res.kind   = KIND_STATUS;
                            direct_res.status = ST_FULL;
                        end else begin
                            mem_we = 1'b1;
                            if (i_req.left) begin
                                n_head  = (r_head == '0) ? IDX_W'(DEPTH - 1)
                                                         : r_head - IDX_W'(1);
                                wr_addr = n_head;
                            end else begin
                                wr_addr = wrap_add(r_head, r_count);
                            end
                            n_count = r_count + CNT_W'(1);
                            n_pos   = '0;
                            n_state = S_LIST;
                        end
                    end else if (i_req.is_pop) begin
                        if (is_empty) begin
                            direct_vld        = 1'b1;
                            direct_res.kind   = KIND_STATUS;
                            direct_res.status = ST_EMPTY;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            if (i_req.left) begin
                                n_head = (r_head == IDX_W'(DEPTH - 1)) ? '0
                                                                       : r_head + IDX_W'(1);
                                n_pos  = '0;
                                // nothing to list once the last element is gone
                                if (r_count != CNT_W'(1)) begin
                                    n_state = S_LIST;
                                end
                            end
                        end
                    end else if (i_req.is_ask) begin
                        direct_vld        = 1'b1;
                        direct_res.kind   = KIND_ANSWER;
                        direct_res.answer = i_req.left ? is_full : is_empty;
                    end else begin
                        if (is_empty) begin
                            direct_vld        = 1'b1;
                            direct_res.kind   = KIND_STATUS;
                            direct_res.status = ST_EMPTY;
                        end else begin
                            n_rd_vld  = 1'b1;
                            n_rd_last = 1'b1;
                            rd_addr   = i_req.left ? r_head
                                                   : wrap_add(r_head, r_count - CNT_W'(1));
                        end
                    end
                end
            end
            S_LIST: begin
                if (out_room) begin
                    n_rd_vld  = 1'b1;
                    rd_addr   = wrap_add(r_head, r_pos);
                    n_rd_last = (r_pos + CNT_W'(1) == r_count);
                    n_pos     = r_pos + CNT_W'(1);
                    if (n_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // element storage, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            slots[wr_addr] <= i_req.value;
        end
        if (n_rd_vld) begin
            r_rd_data <= slots[rd_addr];
        end
    end

    // result queue; a read result and a direct result never land together
    always_comb begin
        oq_we    = r_rd_vld | direct_vld;
        oq_re    = i_pop & ~o_empty;
        oq_wdata = direct_res;
        if (r_rd_vld) begin
            oq_wdata         = '0;
            oq_wdata.kind    = KIND_ELEM;
            oq_wdata.status  = ST_OK;
            oq_wdata.element = r_rd_data;
            oq_wdata.last    = r_rd_last;
        end
        n_owp = r_owp;
        n_orp = r_orp;
        if (oq_we) begin
            n_owp = (r_owp == OA_W'(OUTD - 1)) ? '0 : r_owp + OA_W'(1);
        end
        if (oq_re) begin
            n_orp = (r_orp == OA_W'(OUTD - 1)) ? '0 : r_orp + OA_W'(1);
        end
        n_occ = r_occ + OC_W'(oq_we) - OC_W'(oq_re);
    end

    assign o_empty = (r_occ == '0);
    assign o_res   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        r_rd_last <= n_rd_last;
        if (oq_we) begin
            r_oq[r_owp] <= oq_wdata;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_cap    <= CAP_RESET;
            r_rd_vld <= 1'b0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_occ    <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_rd_vld <= n_rd_vld;
            r_owp    <= n_owp;
            r_orp    <= n_orp;
            r_occ    <= n_occ;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

endmodule
